### hw/rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the LRU key/value cache: field widths,
// request codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int DEF_ENTRIES = 16;

    // capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // request codes
    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    // value returned by a get that misses
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_PICK,
        ST_UPDATE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic match;
        logic pick;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_stall;
    } t_status;

endpackage

### hw/rtl/lkv_if.sv
// ----------------------------------------------------------------------------
// lkv_if
// Valid/ready channels of the cache: the request channel and the response
// channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface lkv_req_if import lkv_pkg::*;;
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [DATA_W-1:0] lookup_key;
    logic [DATA_W-1:0] put_value;

    modport source (output valid, req_type, lookup_key, put_value, input ready);
    modport sink   (input valid, req_type, lookup_key, put_value, output ready);
endinterface

interface lkv_rsp_if import lkv_pkg::*;;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [DATA_W-1:0] evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

### hw/rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   i_req is a valid/ready request channel: req_type (0 get, 1 put),
//   lookup_key and put_value. o_rsp is a valid/ready response channel with
//   one response per request: hit, read_value (value on a get hit, all ones
//   on a get miss, zero on a put), evicted and evicted_key.
//   i_cfg_we/i_cfg_wdata write the capacity register (0 acts as 1, values
//   above ENTRIES act as ENTRIES); write it only while no request is pending.
//   Each request goes through accept, key compare in every cell, select
//   of the first match and eviction decision, then the move-to-front update,
//   which also loads the response register. The sequencer handles one
//   request at a time and takes a new one only after the update step.
//   If the receiver stalls, the response waits in its register and the next
//   request is still accepted and worked up to its update step, where it
//   holds until the waiting response is taken.
//   Reset (synchronous, active low) empties the cache, sets capacity to 16
//   and drops any pending response.
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkv_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    lkv_req_if.sink          i_req,
    lkv_rsp_if.source        o_rsp,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_req_ready;

    assign i_req.ready = w_req_ready;

    // sequencer
    lkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (w_status),
        .o_req_ready (w_req_ready),
        .o_cmd       (w_cmd)
    );

    // cells, compare and response
    lkv_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_req_type   (i_req.req_type),
        .i_lookup_key (i_req.lookup_key),
        .i_put_value  (i_req.put_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_rsp        (o_rsp)
    );

endmodule

### hw/rtl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer of the cache: takes one request, then steps the datapath through
// compare, select and update, holding in update while the response slot is
// full.
// ----------------------------------------------------------------------------
module lkv_ctrl import lkv_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    input  t_status i_status,
    output logic    o_req_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) n_state = ST_MATCH;
            end
            ST_MATCH: begin
                n_state = ST_PICK;
            end
            ST_PICK: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!i_status.out_stall) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            ST_MATCH: begin
                o_cmd.match = 1'b1;
            end
            ST_PICK: begin
                o_cmd.pick = 1'b1;
            end
            ST_UPDATE: begin
                o_cmd.commit = !i_status.out_stall;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/lkv_dp.sv
// ----------------------------------------------------------------------------
// lkv_dp
// Datapath of the cache: a row of key/value cells in recency order (cell 0 is
// the most recent), per-cell key compare, first-match select and the
// move-to-front shift, plus the capacity register and the response register.
// ----------------------------------------------------------------------------
module lkv_dp import lkv_pkg::*; #(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic              i_req_type,
    input  logic [DATA_W-1:0] i_lookup_key,
    input  logic [DATA_W-1:0] i_put_value,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    lkv_rsp_if.source         o_rsp
);

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // cell storage
    logic [DATA_W-1:0]  r_keys [ENTRIES];
    logic [DATA_W-1:0]  r_vals [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]   r_count;
    logic [CAP_W-1:0]   r_capacity;

    // latched request and per-request work registers
    logic               r_req_type;
    logic [DATA_W-1:0]  r_key;
    logic [DATA_W-1:0]  r_val;
    logic [ENTRIES-1:0] r_match;
    logic [ENTRIES-1:0] r_last;
    logic [ENTRIES-1:0] r_first;
    logic               r_hit;
    logic               r_evict;

    // response register
    logic               r_out_valid;
    logic               r_out_hit;
    logic [DATA_W-1:0]  r_out_read_value;
    logic               r_out_evicted;
    logic [DATA_W-1:0]  r_out_evicted_key;

    logic [ENTRIES-1:0] n_match;
    logic [ENTRIES-1:0] n_last;
    logic [ENTRIES-1:0] n_first;
    logic               n_evict;
    logic [CMP_W-1:0]   w_cap_ext;
    logic [CMP_W-1:0]   w_eff_cap;
    logic [ENTRIES-1:0] w_upto;
    logic [ENTRIES-1:0] w_mask;
    logic [DATA_W-1:0]  w_hit_value;
    logic [DATA_W-1:0]  w_evict_key;
    logic [DATA_W-1:0]  w_front_val;
    logic               w_is_put;
    logic               w_shift;
    logic               w_insert;
    logic               w_evicted;

    // compare stage: per-cell key match and the last valid cell
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_match[i] = r_valid[i] && (r_keys[i] == r_key);
        end
        n_last = r_valid & ~(r_valid >> 1);
    end

    // select stage: lowest matching cell, eviction decision
    always_comb begin
        n_first   = r_match & (~r_match + ENTRIES'(1));
        w_cap_ext = CMP_W'(r_capacity);
        priority if (w_cap_ext == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (w_cap_ext > CMP_W'(ENTRIES)) begin
            w_eff_cap = CMP_W'(ENTRIES);
        end else begin
            w_eff_cap = w_cap_ext;
        end
        n_evict = (CMP_W'(r_count) >= w_eff_cap);
    end

    // update stage: read selected cells, build shift mask
    always_comb begin
        w_hit_value = '0;
        w_evict_key = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_upto[i]   = |(r_first >> i);
            w_hit_value = w_hit_value | (r_vals[i] & {DATA_W{r_first[i]}});
            w_evict_key = w_evict_key | (r_keys[i] & {DATA_W{r_last[i]}});
        end
        w_is_put    = (r_req_type == REQ_PUT);
        w_mask      = r_hit ? w_upto : '1;
        w_front_val = w_is_put ? r_val : w_hit_value;
        w_shift     = i_cmd.commit && (r_hit || w_is_put);
        w_insert    = i_cmd.commit && w_is_put && !r_hit && !r_evict;
        w_evicted   = w_is_put && !r_hit && r_evict;
    end

    assign o_status.out_stall = r_out_valid && !o_rsp.ready;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_key      <= i_lookup_key;
            r_val      <= i_put_value;
        end
        if (i_cmd.match) begin
            r_match <= n_match;
            r_last  <= n_last;
        end
        if (i_cmd.pick) begin
            r_first <= n_first;
            r_hit   <= |r_match;
            r_evict <= n_evict;
        end
        // move to front; on a put miss every cell moves back one place
        if (w_shift) begin
            r_keys[0] <= r_key;
            r_vals[0] <= w_front_val;
            for (int i = 1; i < ENTRIES; i++) begin
                if (w_mask[i]) begin
                    r_keys[i] <= r_keys[i-1];
                    r_vals[i] <= r_vals[i-1];
                end
            end
        end
        if (i_cmd.commit) begin
            r_out_hit         <= r_hit;
            r_out_read_value  <= w_is_put ? '0 : (r_hit ? w_hit_value : MISS_VALUE);
            r_out_evicted     <= w_evicted;
            r_out_evicted_key <= w_evicted ? w_evict_key : '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            // valid cells stay a prefix; an insert grows it by one
            if (w_insert) begin
                r_valid <= r_valid | ((r_valid << 1) | ENTRIES'(1));
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.read_value  = r_out_read_value;
    assign o_rsp.evicted     = r_out_evicted;
    assign o_rsp.evicted_key = r_out_evicted_key;

    // valid cells always form a prefix starting at cell 0
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_valid + ENTRIES'(1)) & r_valid) == '0)
        else $error("valid cells are not a prefix");

    // count tracks the number of valid cells
    a_count_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_count))
        else $error("entry count out of step with valid cells");

    // a key is held in at most one cell
    a_unique_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pick |-> $onehot0(r_match))
        else $error("key stored in more than one cell");

    // a response is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |-> !i_cmd.commit)
        else $error("response overwritten while stalled");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lru_key_value_cache. Requests go in through a
// queue-fed driver, and a behavioral LRU store predicts each response. A
// monitor compares every response field with the oldest prediction. The run
// has a short directed part first. Random phases follow, each with its own
// capacity setting and its own mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import lkv_pkg::*;

    localparam int CACHE_SLOTS    = DEF_ENTRIES;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 92;
    localparam int KEY_POOL_SIZE  = 20;
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH,
        IDLE_HOLD
    } t_idle_mode;

    typedef struct packed {
        logic              req_type;
        logic [DATA_W-1:0] lookup_key;
        logic [DATA_W-1:0] put_value;
    } t_cache_req;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_value;
        logic              evicted;
        logic [DATA_W-1:0] evicted_key;
    } t_cache_rsp;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_wdata;

    lkv_req_if req_ch ();
    lkv_rsp_if rsp_ch ();

    // requests waiting for the driver, responses waiting for the monitor
    t_cache_req requests_to_send[$];
    t_cache_rsp lookup_results_due[$];

    // behavioral copy of the store, slot 0 most recently used
    logic [DATA_W-1:0] store_keys [CACHE_SLOTS];
    logic [DATA_W-1:0] store_vals [CACHE_SLOTS];
    int unsigned       store_count;
    logic [CAP_W-1:0]  store_capacity;

    logic [DATA_W-1:0] key_pool [KEY_POOL_SIZE];
    int unsigned       sender_idle_pct;
    int unsigned       receiver_stall_pct;
    bit                long_hold_on;
    int unsigned       hold_count;
    int unsigned       quiet_cycles;
    int                mismatches;

    logic [CAP_W-1:0] phase_capacity [RAND_PHASES] = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd1, 5'd8,
        5'd17, 5'd12};
    t_idle_mode       phase_mode [RAND_PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER,
        IDLE_BOTH, IDLE_HOLD, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

    lru_key_value_cache #(
        .ENTRIES(CACHE_SLOTS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // zero acts as one, anything above the slot count as the slot count
    function automatic int unsigned effective_capacity(input logic [CAP_W-1:0] cap);
        if (cap == 0) return 1;
        if (cap > CACHE_SLOTS) return CACHE_SLOTS;
        return cap;
    endfunction

    // move slot pos to the front, shifting the younger slots back by one
    function automatic void promote_slot(input int unsigned pos);
        logic [DATA_W-1:0] k;
        logic [DATA_W-1:0] v;
        k = store_keys[pos];
        v = store_vals[pos];
        for (int i = pos; i > 0; i--) begin
            store_keys[i] = store_keys[i-1];
            store_vals[i] = store_vals[i-1];
        end
        store_keys[0] = k;
        store_vals[0] = v;
    endfunction

    function automatic t_cache_rsp cache_access(input t_cache_req rq);
        t_cache_rsp  rsp;
        bit          found;
        int unsigned pos;
        rsp   = '0;
        found = 1'b0;
        pos   = 0;
        for (int i = 0; i < store_count; i++) begin
            if (!found && store_keys[i] == rq.lookup_key) begin
                found = 1'b1;
                pos   = i;
            end
        end
        rsp.hit = found;
        if (rq.req_type == REQ_GET) begin
            if (found) begin
                rsp.read_value = store_vals[pos];
                promote_slot(pos);
            end else begin
                rsp.read_value = MISS_VALUE;
            end
        end else if (found) begin
            store_vals[pos] = rq.put_value;
            promote_slot(pos);
        end else begin
            // a lowered capacity still evicts only one entry per insert
            if (store_count >= effective_capacity(store_capacity) && store_count > 0) begin
                rsp.evicted     = 1'b1;
                rsp.evicted_key = store_keys[store_count-1];
                store_count--;
            end
            for (int i = store_count; i > 0; i--) begin
                store_keys[i] = store_keys[i-1];
                store_vals[i] = store_vals[i-1];
            end
            store_keys[0] = rq.lookup_key;
            store_vals[0] = rq.put_value;
            store_count++;
        end
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [DATA_W-1:0] edge_word(input int unsigned idx);
        case (idx)
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    // mostly keys from a small pool so gets and puts hit often
    function automatic t_cache_req random_request(input int unsigned span);
        t_cache_req  rq;
        int unsigned roll;
        roll        = $urandom_range(99);
        rq.req_type = ($urandom_range(1) == 0) ? REQ_GET : REQ_PUT;
        if (roll < 85) begin
            rq.lookup_key = key_pool[$urandom_range(span - 1)];
        end else if (roll < 90) begin
            rq.lookup_key = edge_word($urandom_range(3));
        end else begin
            rq.lookup_key = $urandom;
        end
        rq.put_value = ($urandom_range(9) == 0) ? edge_word($urandom_range(3)) : $urandom;
        return rq;
    endfunction

    task automatic queue_request(input logic kind, input logic [DATA_W-1:0] key,
                                 input logic [DATA_W-1:0] value);
        t_cache_req rq;
        rq.req_type   = kind;
        rq.lookup_key = key;
        rq.put_value  = value;
        requests_to_send.push_back(rq);
    endtask

    // returns at a falling edge with no request queued, offered or in flight
    task automatic wait_until_drained();
        @(negedge clk);
        while (requests_to_send.size() != 0 || req_ch.valid || lookup_results_due.size() != 0)
            @(negedge clk);
    endtask

    // called only while the cache is idle
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we    <= 1'b0;
        store_capacity = cap;
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Request driver: predicts on accept, offers the next queued request
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_cache_req sent;
        t_cache_req nxt;
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                sent.req_type   = req_ch.req_type;
                sent.lookup_key = req_ch.lookup_key;
                sent.put_value  = req_ch.put_value;
                lookup_results_due.push_back(cache_access(sent));
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (requests_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    nxt = requests_to_send.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.req_type   <= nxt.req_type;
                    req_ch.lookup_key <= nxt.lookup_key;
                    req_ch.put_value  <= nxt.put_value;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response ready: random stalls, plus one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            hold_count   <= 0;
        end else if (long_hold_on && hold_count < LONG_HOLD) begin
            rsp_ch.ready <= 1'b0;
            hold_count   <= hold_count + 1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_cache_rsp want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (lookup_results_due.size() == 0) begin
                $error("response with no request outstanding: hit %b value %h",
                       rsp_ch.hit, rsp_ch.read_value);
                mismatches++;
            end else begin
                want = lookup_results_due.pop_front();
                check_field("hit", DATA_W'(want.hit), DATA_W'(rsp_ch.hit));
                check_field("read_value", want.read_value, rsp_ch.read_value);
                check_field("evicted", DATA_W'(want.evicted), DATA_W'(rsp_ch.evicted));
                check_field("evicted_key", want.evicted_key, rsp_ch.evicted_key);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any request or response moving
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned span;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_GET;
        req_ch.lookup_key  = '0;
        req_ch.put_value   = '0;
        rsp_ch.ready       = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = CAP_RESET;
        rst_n              = 1'b0;
        store_count        = 0;
        store_capacity     = CAP_RESET;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        long_hold_on       = 1'b0;
        quiet_cycles       = 0;
        mismatches         = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty store, extreme keys and values, update, hit and miss
        queue_request(REQ_GET, 32'h8000_0000, 32'h0000_0000);
        queue_request(REQ_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
        queue_request(REQ_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
        queue_request(REQ_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_request(REQ_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
        queue_request(REQ_GET, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        queue_request(REQ_PUT, 32'h8000_0000, 32'h1234_5678);
        queue_request(REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        queue_request(REQ_GET, 32'h0000_0001, 32'h0000_0000);
        queue_request(REQ_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        wait_until_drained();

        // capacity dropped below the count: one eviction per new key
        write_capacity(5'd2);
        @(negedge clk);
        queue_request(REQ_PUT, 32'h0000_0010, 32'hA5A5_A5A5);
        queue_request(REQ_PUT, 32'h0000_0020, 32'h0000_0001);
        queue_request(REQ_GET, 32'h0000_0010, 32'h0000_0000);
        queue_request(REQ_GET, 32'h0000_0000, 32'h0000_0000);
        queue_request(REQ_PUT, 32'h0000_0010, 32'hC3C3_C3C3);
        queue_request(REQ_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        wait_until_drained();

        write_capacity(5'd1);
        @(negedge clk);
        queue_request(REQ_PUT, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        queue_request(REQ_GET, 32'hDEAD_BEEF, 32'h0000_0000);
        queue_request(REQ_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
        queue_request(REQ_GET, 32'h0000_0010, 32'h0000_0000);
        wait_until_drained();

        // random phases, each with its own capacity and idling mix
        for (int p = 0; p < RAND_PHASES; p++) begin
            write_capacity(phase_capacity[p]);
            @(negedge clk);
            case (phase_mode[p])
                IDLE_SENDER: begin
                    sender_idle_pct    = 53;
                    receiver_stall_pct = 0;
                end
                IDLE_RECEIVER: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 53;
                end
                IDLE_BOTH: begin
                    sender_idle_pct    = 19;
                    receiver_stall_pct = 19;
                end
                default: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            long_hold_on = (phase_mode[p] == IDLE_HOLD);
            span = effective_capacity(phase_capacity[p]) + 4;
            for (int k = 0; k < KEY_POOL_SIZE; k++)
                key_pool[k] = $urandom;
            key_pool[0] = edge_word(p % 4);
            repeat (PHASE_ITEMS) requests_to_send.push_back(random_request(span));
            wait_until_drained();
            long_hold_on = 1'b0;
        end

        // catch any stray response after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && lookup_results_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_if.sv
hw/rtl/lkv_ctrl.sv
hw/rtl/lkv_dp.sv
hw/rtl/lru_key_value_cache.sv
tb/testbench.sv
